### rtl/fbsa_pkg.sv
// Package for the free block stack allocator: field widths, command and status
// codes, register indexes and the control struct between the top level and the stack.
// Depends on nothing; every other file imports it.
package fbsa_pkg;

  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;
  localparam int BYTES_W      = 25;
  localparam int ADDR_W       = 48;
  localparam int CFG_DATA_W   = 48;
  localparam int CFG_IDX_W    = 2;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;

  localparam int DEFAULT_STACK_DEPTH = 1024;

  // Largest pool size that fits the pool_blocks register, plus one.
  localparam int POOL_LIMIT = 2 ** CNT_W;

  localparam logic [CNT_W-1:0]   POOL_BLOCKS_RST  = CNT_W'(1024);
  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST  = BYTES_W'(4096);
  localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_BLOCKS  = 2'd0,
    REG_BLOCK_BYTES  = 2'd1,
    REG_BASE_ADDRESS = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_REFILL = 2'd3
  } stack_op_e;

  typedef struct packed {
    stack_op_e         op;
    logic [IDX_W-1:0]  push_idx;
  } stack_ctrl_t;

endpackage

### rtl/fbsa_cmd_if.sv
// Command channel of the free block stack allocator: valid, ready and payload.
// Depends on fbsa_pkg.
interface fbsa_cmd_if;
  import fbsa_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] free_index;

  modport source (output valid, output cmd, output free_index, input ready);
  modport sink   (input valid, input cmd, input free_index, output ready);
endinterface

### rtl/fbsa_rsp_if.sv
// Result channel of the free block stack allocator: valid, ready and payload.
// Depends on fbsa_pkg.
interface fbsa_rsp_if;
  import fbsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    block_index;
  logic [ADDR_W-1:0]   block_address;
  logic [CNT_W-1:0]    free_count;

  modport source (output valid, output status, output block_index, output block_address,
                  output free_count, input ready);
  modport sink   (input valid, input status, input block_index, input block_address,
                  input free_count, output ready);
endinterface

### rtl/fbsa_cell.sv
// One cell of the shift-register stack: holds one entry and moves it to a neighbor.
// Depends on fbsa_pkg.
module fbsa_cell #(
  parameter int               VAL_W     = 10,
  parameter logic [VAL_W-1:0] RESET_VAL = '0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fbsa_pkg::stack_op_e   op_i,
  input  logic [VAL_W-1:0]      from_up_i,
  input  logic [VAL_W-1:0]      from_down_i,
  output logic [VAL_W-1:0]      val_o
);
  import fbsa_pkg::*;

  logic [VAL_W-1:0] val_q;

  // The refill value is the cell's own depth, so a refill restores ascending pop order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= RESET_VAL;
    end else begin
      case (op_i)
        OP_PUSH:   val_q <= from_up_i;
        OP_POP:    val_q <= from_down_i;
        OP_REFILL: val_q <= RESET_VAL;
        default:   val_q <= val_q;
      endcase
    end
  end

  assign val_o = val_q;

endmodule

### rtl/fbsa_stack.sv
// Chain of stack cells with the top of stack in cell zero.
// Depends on fbsa_pkg and fbsa_cell.
module fbsa_stack #(
  parameter int STACK_DEPTH = fbsa_pkg::DEFAULT_STACK_DEPTH,
  parameter int VAL_W       = fbsa_pkg::IDX_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fbsa_pkg::stack_ctrl_t ctrl_i,
  output logic [VAL_W-1:0]      top_o
);
  import fbsa_pkg::*;

  logic [VAL_W-1:0] cell_val [STACK_DEPTH];

  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    logic [VAL_W-1:0] up_val;
    logic [VAL_W-1:0] down_val;

    if (k == 0) begin : g_top
      assign up_val = VAL_W'(ctrl_i.push_idx);
    end else begin : g_mid_up
      assign up_val = cell_val[k-1];
    end

    // The bottom cell keeps its own value on a pop; that slot is beyond the count.
    if (k == STACK_DEPTH - 1) begin : g_bottom
      assign down_val = cell_val[k];
    end else begin : g_mid_down
      assign down_val = cell_val[k+1];
    end

    fbsa_cell #(
      .VAL_W     (VAL_W),
      .RESET_VAL (VAL_W'(k))
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (ctrl_i.op),
      .from_up_i   (up_val),
      .from_down_i (down_val),
      .val_o       (cell_val[k])
    );
  end

  assign top_o = cell_val[0];

endmodule

### rtl/free_block_stack_allocator.sv
// Free block stack allocator: LIFO of free block indices with address generation.
// The result and the stack update of a command are registered on its accepting edge.
// One command per cycle unless a result stalls; push, pop and refill update all cells.
// Reset: async, clears the handshake and frees min(STACK_DEPTH, 1024) blocks, ascending.
// Depends on fbsa_pkg, fbsa_cmd_if, fbsa_rsp_if and fbsa_stack.
module free_block_stack_allocator #(
  parameter int STACK_DEPTH = fbsa_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbsa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbsa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fbsa_cmd_if.sink                        cmd_i,
  fbsa_rsp_if.source                      rsp_o
);
  import fbsa_pkg::*;

  // The count has to hold the full depth itself.
  localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
  // Refilled entries are bounded by the pool register; pushed entries are index wide.
  localparam int REFILL_MAX = (STACK_DEPTH < POOL_LIMIT) ? STACK_DEPTH : POOL_LIMIT;
  localparam int REFILL_W   = $clog2(REFILL_MAX);
  localparam int VAL_W      = (REFILL_W > IDX_W) ? REFILL_W : IDX_W;
  localparam int PROD_W     = VAL_W + BYTES_W;
  localparam int CMP_W      = (COUNT_W > CNT_W) ? COUNT_W : CNT_W;
  localparam int RST_BLOCKS = (STACK_DEPTH < 1024) ? STACK_DEPTH : 1024;

  // Configuration registers. They only feed the next refill and the address arithmetic.
  logic [CNT_W-1:0]   pool_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [ADDR_W-1:0]  base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q  <= POOL_BLOCKS_RST;
      bytes_q <= BLOCK_BYTES_RST;
      base_q  <= BASE_ADDRESS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_POOL_BLOCKS:  pool_q  <= cfg_data_i[CNT_W-1:0];
        REG_BLOCK_BYTES:  bytes_q <= cfg_data_i[BYTES_W-1:0];
        REG_BASE_ADDRESS: base_q  <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. A single output register parts the channels: a new command is taken
  // whenever the held result leaves in the same cycle or no result is held.
  logic rsp_valid_q;
  logic cmd_accept;
  logic rsp_accept;

  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign cmd_accept  = cmd_i.valid && cmd_i.ready;
  assign rsp_accept  = rsp_valid_q && rsp_o.ready;

  // Stack control. The top of stack always sits in cell zero, so a pop reads it
  // directly and the whole chain shifts by one entry in the same edge.
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] count_d;
  logic [COUNT_W-1:0] refill_cnt;
  logic [CMP_W-1:0]   pool_ext;
  logic [VAL_W-1:0]   top_val;
  stack_ctrl_t        stack_ctrl;
  status_e            status_d;
  logic               hit_d;
  cmd_e               cmd;

  assign cmd      = cmd_e'(cmd_i.cmd);
  assign pool_ext = CMP_W'(pool_q);
  // A pool larger than the stack is clipped to the stack depth.
  assign refill_cnt = (pool_ext > CMP_W'(STACK_DEPTH)) ? COUNT_W'(STACK_DEPTH)
                                                       : COUNT_W'(pool_ext);

  always_comb begin
    count_d             = count_q;
    status_d            = ST_OK;
    hit_d               = 1'b0;
    stack_ctrl.op       = OP_HOLD;
    stack_ctrl.push_idx = cmd_i.free_index;
    if (cmd_accept) begin
      case (cmd)
        CMD_ALLOC: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            stack_ctrl.op = OP_POP;
            count_d       = count_q - COUNT_W'(1);
            hit_d         = 1'b1;
          end
        end
        CMD_FREE: begin
          // Pushing onto a full stack is reported and the index is dropped.
          if (count_q == COUNT_W'(STACK_DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            stack_ctrl.op = OP_PUSH;
            count_d       = count_q + COUNT_W'(1);
          end
        end
        CMD_RESET: begin
          stack_ctrl.op = OP_REFILL;
          count_d       = refill_cnt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(RST_BLOCKS);
    end else begin
      count_q <= count_d;
    end
  end

  fbsa_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .VAL_W       (VAL_W)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (stack_ctrl),
    .top_o  (top_val)
  );

  // Result register. The product index times block size is registered here; the base
  // is added on the output side, so multiplier and adder sit in different stages.
  status_e            status_q;
  logic               hit_q;
  logic [VAL_W-1:0]   index_q;
  logic [PROD_W-1:0]  prod_q;
  logic [CNT_W-1:0]   rsp_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_accept) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_accept) begin
      status_q    <= status_d;
      hit_q       <= hit_d;
      index_q     <= hit_d ? top_val : '0;
      prod_q      <= PROD_W'(top_val) * PROD_W'(bytes_q);
      rsp_count_q <= CNT_W'(count_d);
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.block_index   = index_q[IDX_W-1:0];
  assign rsp_o.block_address = hit_q ? ADDR_W'(base_q + ADDR_W'(prod_q)) : '0;
  assign rsp_o.free_count    = rsp_count_q;

  // The free count can never pass the stack depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(STACK_DEPTH))
    else $error("free count exceeds stack depth");

  // An allocate on an empty pool reports empty in the next result and leaves the count.
  a_empty_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_accept && cmd == CMD_ALLOC && count_q == '0)
      |=> (rsp_valid_q && status_q == ST_EMPTY && count_q == '0))
    else $error("allocate on empty pool mishandled");

  // While a result is stalled no command enters, so the stack count holds.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |=> $stable(count_q))
    else $error("stack changed while result stalled");

endmodule
